@@ hdl/ssfl_pkg.sv @@
`timescale 1ns / 1ps

package ssfl_pkg;

  localparam int CHAR_W    = 8;
  localparam int PAT_BYTES = 8;
  localparam int PAT_W     = CHAR_W * PAT_BYTES;
  localparam int PLEN_W    = 4;
  localparam int POS_W     = 16;
  localparam int CFG_IDX_W = 8;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_PATTERN          = 8'd0;
  localparam cfg_idx_t REG_PATTERN_LENGTH   = 8'd1;
  localparam cfg_idx_t REG_CASE_INSENSITIVE = 8'd2;
  localparam cfg_idx_t REG_FIND_LAST        = 8'd3;

  localparam logic [CHAR_W-1:0] LETTER_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] LETTER_UPPER_Z = 8'h5A;
  localparam logic [CHAR_W-1:0] FOLD_OFFSET    = 8'h20;

  typedef struct packed {
    logic [PAT_W-1:0]  pattern;
    logic [PLEN_W-1:0] pattern_length;
    logic              case_insensitive;
    logic              find_last;
  } cfg_t;

endpackage

@@ hdl/ssfl_text_if.sv @@
`timescale 1ns / 1ps

interface ssfl_text_if;
  logic                        valid;
  logic                        ready;
  logic [ssfl_pkg::CHAR_W-1:0] text_byte;
  logic                        has_byte;
  logic                        last_byte;

  modport source (output valid, output text_byte, output has_byte, output last_byte,
                  input ready);
  modport sink   (input valid, input text_byte, input has_byte, input last_byte,
                  output ready);
endinterface

@@ hdl/ssfl_result_if.sv @@
`timescale 1ns / 1ps

interface ssfl_result_if;
  logic                       valid;
  logic                       ready;
  logic                       found;
  logic [ssfl_pkg::POS_W-1:0] match_position;
  logic                       too_long;

  modport source (output valid, output found, output match_position, output too_long,
                  input ready);
  modport sink   (input valid, input found, input match_position, input too_long,
                  output ready);
endinterface

@@ hdl/ssfl_cfg_if.sv @@
`timescale 1ns / 1ps

interface ssfl_cfg_if;
  logic                       valid;
  logic                       ready;
  ssfl_pkg::cfg_idx_t         index;
  logic [ssfl_pkg::PAT_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hdl/substring_search_first_last.sv @@
`timescale 1ns / 1ps

// Streaming substring search, first or last match.
// Channels: text_in takes one text byte per beat (has_byte marks a real byte,
// last_byte closes the text); result_out gives one beat per text with found,
// match_position and too_long; cfg writes pattern (0), pattern_length (1),
// case_insensitive (2) and find_last (3), always ready; the user must use cfg
// only while idle; the block does not enforce it. Throughput: one text beat
// per clock unless a closing beat waits. Each beat lands in an input register,
// then the window compare, counter and match tracking run in one pass and the
// result register loads on the closing beat, which reaches result_out.valid
// through the input and result registers. A stalled result_out holds its
// beat; text_in then keeps taking bytes that are not closing beats, and a
// closing beat waits in the input register until the result register frees.
// Reset clears the configuration, the byte count, the match record and both
// valid flags. After each result the search state returns to that state,
// configuration kept. Texts beyond TEXT_MAX_LEN bytes are truncated and
// flagged too_long.
module substring_search_first_last #(
  parameter int              PATTERN_MAX  = 8,
  parameter longint unsigned TEXT_MAX_LEN = 65535
) (
  input  logic           clk,
  input  logic           rst,
  ssfl_text_if.sink      text_in,
  ssfl_result_if.source  result_out,
  ssfl_cfg_if.sink       cfg
);

  localparam int CNT_W = $clog2(TEXT_MAX_LEN + 64'd2);
  localparam logic [CNT_W-1:0] LIMIT = CNT_W'(TEXT_MAX_LEN);
  localparam logic [CNT_W-1:0] SAT   = CNT_W'(TEXT_MAX_LEN + 64'd1);

  ssfl_pkg::cfg_t regs;

  // input register
  logic                        in_valid;
  logic [ssfl_pkg::CHAR_W-1:0] in_byte;
  logic                        in_has;
  logic                        in_last;

  // search state
  logic [CNT_W-1:0]           count, count_next;
  logic                       seen, seen_next;
  logic [ssfl_pkg::POS_W-1:0] start, start_next;

  logic out_free, fire, take, hit, too_long_c;
  logic [CNT_W-1:0] text_len;
  logic                       found_c;
  logic [ssfl_pkg::POS_W-1:0] pos_c;

  ssfl_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  ssfl_matcher #(
    .PATTERN_MAX (PATTERN_MAX),
    .CNT_W       (CNT_W)
  ) u_matcher (
    .clk        (clk),
    .regs       (regs),
    .shift_en   (fire && take),
    .text_byte  (in_byte),
    .count_next (count_next),
    .hit        (hit)
  );

  assign out_free      = !result_out.valid || result_out.ready;
  assign fire          = in_valid && (!in_last || out_free);
  assign text_in.ready = !in_valid || fire;

  assign take = in_has && (count < LIMIT);

  // byte count kept apart from match tracking: hit depends on count_next
  always_comb begin
    count_next = count;
    if (take) begin
      count_next = count + CNT_W'(1);
    end else if (in_has) begin
      count_next = SAT;
    end
  end

  always_comb begin
    seen_next  = seen;
    start_next = start;
    if (take && hit && (!seen || regs.find_last)) begin
      seen_next  = 1'b1;
      start_next = ssfl_pkg::POS_W'(count_next - CNT_W'(regs.pattern_length));
    end
  end

  assign too_long_c = (count_next > LIMIT);
  assign text_len   = too_long_c ? LIMIT : count_next;

  always_comb begin
    if (regs.pattern_length == '0) begin
      found_c = 1'b1;
      pos_c   = regs.find_last ? ssfl_pkg::POS_W'(text_len) : '0;
    end else if (seen_next) begin
      found_c = 1'b1;
      pos_c   = start_next;
    end else begin
      found_c = 1'b0;
      pos_c   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (text_in.valid && text_in.ready) begin
      in_valid <= 1'b1;
    end else if (fire) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (text_in.valid && text_in.ready) begin
      in_byte <= text_in.text_byte;
      in_has  <= text_in.has_byte;
      in_last <= text_in.last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      seen  <= 1'b0;
      start <= '0;
    end else if (fire) begin
      if (in_last) begin
        count <= '0;
        seen  <= 1'b0;
        start <= '0;
      end else begin
        count <= count_next;
        seen  <= seen_next;
        start <= start_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_out.valid <= 1'b0;
    end else if (fire && in_last) begin
      result_out.valid <= 1'b1;
    end else if (result_out.ready) begin
      result_out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && in_last) begin
      result_out.found          <= found_c;
      result_out.match_position <= pos_c;
      result_out.too_long       <= too_long_c;
    end
  end

endmodule

@@ hdl/ssfl_cfg_regs.sv @@
`timescale 1ns / 1ps

module ssfl_cfg_regs (
  input  logic            clk,
  input  logic            rst,
  ssfl_cfg_if.sink        cfg,
  output ssfl_pkg::cfg_t  regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        ssfl_pkg::REG_PATTERN:          regs.pattern <= cfg.data;
        ssfl_pkg::REG_PATTERN_LENGTH:   regs.pattern_length <= cfg.data[ssfl_pkg::PLEN_W-1:0];
        ssfl_pkg::REG_CASE_INSENSITIVE: regs.case_insensitive <= cfg.data[0];
        ssfl_pkg::REG_FIND_LAST:        regs.find_last <= cfg.data[0];
        default: ;  // unmapped index: beat is dropped
      endcase
    end
  end

endmodule

@@ hdl/ssfl_matcher.sv @@
`timescale 1ns / 1ps

module ssfl_matcher #(
  parameter int PATTERN_MAX = 8,
  parameter int CNT_W       = 17
) (
  input  logic                        clk,
  input  ssfl_pkg::cfg_t              regs,
  input  logic                        shift_en,
  input  logic [ssfl_pkg::CHAR_W-1:0] text_byte,
  input  logic [CNT_W-1:0]            count_next,
  output logic                        hit
);

  localparam int IDX_W     = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int WIN_DEPTH = 2 ** IDX_W;
  localparam logic [ssfl_pkg::PLEN_W-1:0] PMAX = ssfl_pkg::PLEN_W'(PATTERN_MAX);

  // entry 0 holds the newest byte
  logic [ssfl_pkg::CHAR_W-1:0] win      [WIN_DEPTH];
  logic [ssfl_pkg::CHAR_W-1:0] win_next [WIN_DEPTH];
  logic                        eq_all;

  function automatic logic [ssfl_pkg::CHAR_W-1:0] fold(
    input logic [ssfl_pkg::CHAR_W-1:0] c,
    input logic                        ci
  );
    if (ci && c >= ssfl_pkg::LETTER_UPPER_A && c <= ssfl_pkg::LETTER_UPPER_Z)
      return c + ssfl_pkg::FOLD_OFFSET;
    return c;
  endfunction

  always_comb begin
    win_next[0] = text_byte;
    for (int k = 1; k < WIN_DEPTH; k++) begin
      win_next[k] = win[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      win <= win_next;
    end
  end

  // pattern byte j lines up with window entry plen-1-j
  always_comb begin
    logic [ssfl_pkg::PLEN_W-1:0] sel;
    logic [ssfl_pkg::CHAR_W-1:0] pc;
    logic [ssfl_pkg::CHAR_W-1:0] tc;
    eq_all = 1'b1;
    for (int j = 0; j < PATTERN_MAX; j++) begin
      sel = regs.pattern_length - ssfl_pkg::PLEN_W'(j) - ssfl_pkg::PLEN_W'(1);
      pc  = regs.pattern[ssfl_pkg::CHAR_W*j +: ssfl_pkg::CHAR_W];
      tc  = win_next[sel[IDX_W-1:0]];
      if (ssfl_pkg::PLEN_W'(j) < regs.pattern_length &&
          fold(pc, regs.case_insensitive) != fold(tc, regs.case_insensitive)) begin
        eq_all = 1'b0;
      end
    end
  end

  assign hit = (regs.pattern_length != '0) && (regs.pattern_length <= PMAX) &&
               (count_next >= CNT_W'(regs.pattern_length)) && eq_all;

endmodule

@@ hdl/ssfl_checker.sv @@
`timescale 1ns / 1ps

module ssfl_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic                       found,
  input logic [ssfl_pkg::POS_W-1:0] match_position,
  input logic                       too_long
);

  // nothing is offered the cycle after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // input register is empty coming out of reset
  a_ready_after_reset: assert property (@(posedge clk) $past(rst) && !rst |-> in_ready)
    else $error("text input not ready after reset");

  // a miss always reports position zero
  a_miss_pos_zero: assert property (@(posedge clk) disable iff (rst)
      out_valid && !found |-> match_position == '0)
    else $error("not-found result with non-zero position");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
      out_valid && !out_ready |=>
        out_valid && $stable(found) && $stable(match_position) && $stable(too_long))
    else $error("stalled result beat changed");

endmodule

bind substring_search_first_last ssfl_checker u_ssfl_checker (
  .clk            (clk),
  .rst            (rst),
  .in_ready       (text_in.ready),
  .out_valid      (result_out.valid),
  .out_ready      (result_out.ready),
  .found          (result_out.found),
  .match_position (result_out.match_position),
  .too_long       (result_out.too_long)
);

@@ bench/ssfl_search_checker.sv @@
`timescale 1ns / 1ps

module ssfl_search_checker
  import ssfl_pkg::*;
#(
  parameter int              PATTERN_MAX  = 8,
  parameter longint unsigned TEXT_MAX_LEN = 65535
) (
  input  logic   clk,
  input  logic   rst,
  ssfl_text_if   text_mon,
  ssfl_result_if result_mon,
  ssfl_cfg_if    cfg_mon,
  output int     mismatches,
  output int     results_pending
);

  localparam logic [16:0] LEN_CAP = 17'(TEXT_MAX_LEN);

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
    logic             too_long;
  } search_verdict_t;

  cfg_t              search_cfg;
  logic [CHAR_W-1:0] recent [PAT_BYTES];   // entry 0 holds the newest byte
  logic [16:0]       text_count;
  logic              hit_recorded;
  logic [POS_W-1:0]  hit_start;
  search_verdict_t   verdicts_due [$];
  int                fail_count = 0;

  function automatic logic [CHAR_W-1:0] fold_char(input logic [CHAR_W-1:0] c);
    if (search_cfg.case_insensitive && c >= LETTER_UPPER_A && c <= LETTER_UPPER_Z)
      return c + FOLD_OFFSET;
    return c;
  endfunction

  task automatic clear_search();
    foreach (recent[i]) recent[i] = '0;
    text_count   = '0;
    hit_recorded = 1'b0;
    hit_start    = '0;
  endtask

  always @(posedge clk) begin : track
    search_verdict_t due;
    logic            hit;
    int              plen;
    logic [16:0]     text_len;

    if (rst) begin
      search_cfg = '0;
      clear_search();
      verdicts_due.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          REG_PATTERN:          search_cfg.pattern          = cfg_mon.data;
          REG_PATTERN_LENGTH:   search_cfg.pattern_length   = cfg_mon.data[PLEN_W-1:0];
          REG_CASE_INSENSITIVE: search_cfg.case_insensitive = cfg_mon.data[0];
          REG_FIND_LAST:        search_cfg.find_last        = cfg_mon.data[0];
          default: ;
        endcase
      end

      if (text_mon.valid && text_mon.ready) begin
        plen = int'(search_cfg.pattern_length);
        if (text_mon.has_byte) begin
          if (text_count < LEN_CAP) begin
            for (int i = PAT_BYTES - 1; i > 0; i--) recent[i] = recent[i-1];
            recent[0] = text_mon.text_byte;
            text_count++;
            if (plen != 0 && plen <= PATTERN_MAX && plen <= PAT_BYTES &&
                text_count >= 17'(plen)) begin
              hit = 1'b1;
              // pattern char j lines up with the byte plen-1-j beats back
              for (int j = 0; j < plen; j++)
                if (fold_char(search_cfg.pattern[CHAR_W*j +: CHAR_W]) !=
                    fold_char(recent[plen-1-j]))
                  hit = 1'b0;
              if (hit && (!hit_recorded || search_cfg.find_last)) begin
                hit_recorded = 1'b1;
                hit_start    = POS_W'(text_count - 17'(plen));
              end
            end
          end else begin
            text_count = LEN_CAP + 17'd1;
          end
        end

        if (text_mon.last_byte) begin
          due.too_long = (text_count > LEN_CAP);
          text_len     = due.too_long ? LEN_CAP : text_count;
          if (plen == 0) begin
            due.found    = 1'b1;
            due.position = search_cfg.find_last ? POS_W'(text_len) : '0;
          end else if (hit_recorded) begin
            due.found    = 1'b1;
            due.position = hit_start;
          end else begin
            due.found    = 1'b0;
            due.position = '0;
          end
          verdicts_due.push_back(due);
          clear_search();
        end
      end

      if (result_mon.valid && result_mon.ready) begin
        if (verdicts_due.size() == 0) begin
          fail_count++;
          $error("result beat with no search outstanding: found=%0d match_position=%0d too_long=%0d",
                 result_mon.found, result_mon.match_position, result_mon.too_long);
        end else begin
          due = verdicts_due.pop_front();
          if (result_mon.found !== due.found) begin
            fail_count++;
            $error("found: expected %0d, got %0d", due.found, result_mon.found);
          end
          if (result_mon.match_position !== due.position) begin
            fail_count++;
            $error("match_position: expected %0d, got %0d",
                   due.position, result_mon.match_position);
          end
          if (result_mon.too_long !== due.too_long) begin
            fail_count++;
            $error("too_long: expected %0d, got %0d", due.too_long, result_mon.too_long);
          end
        end
      end
    end

    mismatches      <= fail_count;
    results_pending <= verdicts_due.size();
  end

endmodule

@@ bench/tb_substring_search_first_last.sv @@
`timescale 1ns / 1ps

module tb_substring_search_first_last;
  import ssfl_pkg::*;

  localparam int              PAT_LIMIT      = 8;
  localparam longint unsigned TEXT_LIMIT     = 65535;
  localparam int              RANDOM_ITEMS   = 1850;
  localparam int              WATCHDOG_LIMIT = 4000;
  localparam int              SETTLE_CYCLES  = 4;
  localparam int              DRAIN_CYCLES   = 8;

  typedef enum logic [1:0] {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;
  typedef logic [CHAR_W-1:0] char_q_t [$];

  logic clk = 1'b0;
  logic rst = 1'b1;

  ssfl_text_if   text_if ();
  ssfl_result_if result_if ();
  ssfl_cfg_if    cfg_if ();

  int                mismatches;
  int                results_pending;
  logic              take_result  = 1'b0;
  rx_mode_t          rx_mode      = RX_ALWAYS;
  int                rx_left      = 0;
  int                rx_tick      = 0;
  int                quiet_cycles = 0;
  int                burst_left   = 0;
  bit                gaps_on      = 1'b1;
  int                items_sent   = 0;
  logic [PAT_W-1:0]  cur_pattern  = '0;
  logic [PLEN_W-1:0] cur_plen     = '0;
  logic              cur_fold     = 1'b0;

  assign result_if.ready = take_result;

  substring_search_first_last #(
    .PATTERN_MAX  (PAT_LIMIT),
    .TEXT_MAX_LEN (TEXT_LIMIT)
  ) u_dut (
    .clk        (clk),
    .rst        (rst),
    .text_in    (text_if),
    .result_out (result_if),
    .cfg        (cfg_if)
  );

  ssfl_search_checker #(
    .PATTERN_MAX  (PAT_LIMIT),
    .TEXT_MAX_LEN (TEXT_LIMIT)
  ) u_checker (
    .clk             (clk),
    .rst             (rst),
    .text_mon        (text_if),
    .result_mon      (result_if),
    .cfg_mon         (cfg_if),
    .mismatches      (mismatches),
    .results_pending (results_pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // result side back-pressure; the mode is re-picked at random when its countdown runs out
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 3));
      rx_left <= $urandom_range(20, 200);
    end else begin
      rx_left <= rx_left - 1;
    end
    rx_tick <= rx_tick + 1;
    case (rx_mode)
      RX_ALWAYS: take_result <= 1'b1;
      RX_COIN:   take_result <= 1'($urandom_range(0, 1));
      RX_SPARSE: take_result <= ($urandom_range(0, 3) == 0);
      default:   take_result <= (rx_tick % 16 == 0);
    endcase
  end

  always @(posedge clk) begin
    if (rst || (text_if.valid && text_if.ready) || (result_if.valid && result_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("[substring_search_first_last] ERROR");
        $finish;
      end
    end
  end

  function automatic logic [CHAR_W-1:0] flip_case(input logic [CHAR_W-1:0] c);
    if ((c >= LETTER_UPPER_A && c <= LETTER_UPPER_Z) ||
        (c >= LETTER_UPPER_A + FOLD_OFFSET && c <= LETTER_UPPER_Z + FOLD_OFFSET))
      return c ^ FOLD_OFFSET;
    return c;
  endfunction

  function automatic int pattern_span();
    if (cur_plen == 0 || cur_plen > PAT_BYTES)
      return PAT_BYTES;
    return int'(cur_plen);
  endfunction

  // mostly pattern characters so that partial and full matches are common
  function automatic logic [CHAR_W-1:0] pick_char();
    int                sel;
    int                idx;
    logic [CHAR_W-1:0] c;
    sel = $urandom_range(0, 9);
    idx = $urandom_range(0, pattern_span() - 1);
    if (sel < 6)
      c = cur_pattern[CHAR_W*idx +: CHAR_W];
    else if (sel < 8)
      c = LETTER_UPPER_A + CHAR_W'($urandom_range(0, 2));
    else
      c = CHAR_W'($urandom);
    return ($urandom_range(0, 1) != 0) ? flip_case(c) : c;
  endfunction

  function automatic char_q_t random_text(input int len);
    char_q_t           txt;
    int                span;
    logic [CHAR_W-1:0] c;
    span = pattern_span();
    while (txt.size() < len) begin
      if (cur_plen != 0 && $urandom_range(0, 4) == 0) begin
        for (int j = 0; j < span; j++) begin
          c = cur_pattern[CHAR_W*j +: CHAR_W];
          txt.push_back((cur_fold && $urandom_range(0, 1) != 0) ? flip_case(c) : c);
        end
      end else begin
        txt.push_back(pick_char());
      end
    end
    return txt;
  endfunction

  task automatic send_beat(input logic [CHAR_W-1:0] ch, input logic has, input logic closes);
    int gap;
    if (gaps_on && burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 40);
      if (gap != 0) begin
        text_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    if (burst_left > 0) burst_left--;
    text_if.valid     <= 1'b1;
    text_if.text_byte <= ch;
    text_if.has_byte  <= has;
    text_if.last_byte <= closes;
    @(posedge clk);
    while (!text_if.ready) @(posedge clk);
    if (has || closes) items_sent++;
  endtask

  // end_apart closes the text with a byteless beat
  task automatic send_text(input char_q_t txt, input bit end_apart, input int idle_odds);
    bit closes;
    foreach (txt[i]) begin
      if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
        send_beat(CHAR_W'($urandom), 1'b0, 1'b0);
      closes = !end_apart && (i == txt.size() - 1);
      send_beat(txt[i], 1'b1, closes);
    end
    if (end_apart || txt.size() == 0)
      send_beat(CHAR_W'($urandom), 1'b0, 1'b1);
  endtask

  // hold the text side until every result is back, then let the pipe empty
  task automatic settle_block();
    text_if.valid <= 1'b0;
    do @(posedge clk); while (results_pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [PAT_W-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
  endtask

  task automatic load_search(input logic [PAT_W-1:0] pat, input logic [PLEN_W-1:0] plen,
                             input logic fold, input logic rev);
    cur_pattern = pat;
    cur_plen    = plen;
    cur_fold    = fold;
    write_reg(REG_PATTERN, pat);
    write_reg(REG_PATTERN_LENGTH, PAT_W'(plen));
    write_reg(REG_CASE_INSENSITIVE, PAT_W'(fold));
    write_reg(REG_FIND_LAST, PAT_W'(rev));
    cfg_if.valid <= 1'b0;
  endtask

  initial begin
    char_q_t           txt;
    logic [PAT_W-1:0]  pat;
    logic [CHAR_W-1:0] c;
    int                plen;
    int                sel;
    int                phase;
    int                phase_end;
    int                len;

    text_if.valid     <= 1'b0;
    text_if.text_byte <= '0;
    text_if.has_byte  <= 1'b0;
    text_if.last_byte <= 1'b0;
    cfg_if.valid      <= 1'b0;
    cfg_if.index      <= REG_PATTERN;
    cfg_if.data       <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty text on the reset settings: empty pattern, forward
    send_beat(8'h00, 1'b0, 1'b1);
    settle_block();

    // "aB" folded against "xA" idle "bab": first hit at 1
    load_search(64'h4261, 4'd2, 1'b1, 1'b0);
    send_beat(8'h78, 1'b1, 1'b0);
    send_beat(8'h41, 1'b1, 1'b0);
    send_beat(8'h5A, 1'b0, 1'b0);
    txt = '{8'h62, 8'h61, 8'h62};
    send_text(txt, 1'b0, 0);
    settle_block();

    // same text in reverse mode: last hit at 3
    load_search(64'h4261, 4'd2, 1'b1, 1'b1);
    txt = '{8'h78, 8'h41, 8'h62, 8'h61, 8'h62};
    send_text(txt, 1'b0, 0);
    settle_block();

    // empty pattern in reverse mode reports the text length
    load_search('0, 4'd0, 1'b0, 1'b1);
    txt = '{8'h71, 8'h72, 8'h73};
    send_text(txt, 1'b0, 0);
    settle_block();

    // length beyond the window never matches
    load_search('1, 4'd9, 1'b0, 1'b0);
    txt = '{8'hFF, 8'hFF};
    send_text(txt, 1'b0, 0);
    settle_block();

    // full-width pattern, all ones
    load_search('1, 4'd8, 1'b0, 1'b0);
    txt = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_text(txt, 1'b0, 0);
    settle_block();

    // overlong texts: tail bytes dropped, length capped
    gaps_on = 1'b0;
    load_search(64'h7A7A, 4'd2, 1'b0, 1'b1);
    txt.delete();
    repeat (int'(TEXT_LIMIT) + 3) txt.push_back(($urandom_range(0, 1) != 0) ? 8'h7A : 8'h79);
    send_text(txt, 1'b0, 0);
    settle_block();
    load_search('0, 4'd0, 1'b0, 1'b1);
    txt.delete();
    repeat (int'(TEXT_LIMIT) + 1) txt.push_back(CHAR_W'($urandom));
    send_text(txt, 1'b1, 0);
    settle_block();
    gaps_on = 1'b1;

    items_sent = 0;
    phase      = 0;
    while (items_sent < RANDOM_ITEMS) begin
      settle_block();
      if ($urandom_range(0, 4) == 0) begin
        pat = {$urandom, $urandom};
      end else begin
        for (int j = 0; j < PAT_BYTES; j++) begin
          c = ($urandom_range(0, 4) == 0) ? CHAR_W'($urandom)
                                          : LETTER_UPPER_A + CHAR_W'($urandom_range(0, 2));
          pat[CHAR_W*j +: CHAR_W] = ($urandom_range(0, 1) != 0) ? flip_case(c) : c;
        end
      end
      case (phase)
        0: plen = 0;
        1: plen = PAT_BYTES;
        2: plen = 15;
        default: begin
          sel  = $urandom_range(0, 19);
          plen = (sel < 2) ? 0 : (sel < 4) ? $urandom_range(9, 15) : $urandom_range(1, 8);
        end
      endcase
      load_search(pat, PLEN_W'(plen), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      phase++;
      phase_end = items_sent + $urandom_range(60, 200);
      while (items_sent < phase_end) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 64) : $urandom_range(0, 16);
        send_text(random_text(len), $urandom_range(0, 3) == 0, 12);
        if ($urandom_range(0, 9) == 0) settle_block();
      end
    end

    settle_block();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && results_pending == 0) begin
      $display("[substring_search_first_last] OK");
    end else begin
      $display("[substring_search_first_last] ERROR");
    end
    $finish;
  end

endmodule
